### rtl/core/dshr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshr_pkg
// Shared types and constants of the double sample-and-hold rate reducer.
// ----------------------------------------------------------------------------
package dshr_pkg;

   localparam int SAMPLE_W        = 24;
   localparam int TARGET_W        = 17;
   localparam int RAMP_W          = 14;
   localparam int DETUNE_W        = 32;
   localparam int RATIO_W         = 16;
   localparam int PHASE_W         = 16;
   localparam int DEN_W           = 24;
   localparam int CNT_W           = 5;

   localparam int CHANNELS_DEF    = 2;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam logic [RAMP_W-1:0]   RAMP_FRAMES_RESET = 14'd960;
   localparam logic [RAMP_W-1:0]   RAMP_MAX          = 14'd8192;
   localparam logic [TARGET_W-1:0] Q16_ONE           = 17'd65536;
   localparam logic [TARGET_W-1:0] BYPASS_LIMIT      = 17'd66;
   localparam logic [DEN_W-1:0]    RECIP_BASE        = 24'd6553600;
   localparam logic [7:0]          K_STAGE_ONE       = 8'd136;
   localparam logic [7:0]          K_STAGE_TWO       = 8'd68;
   localparam logic [CNT_W-1:0]    DIV_STEPS_LAST    = 5'd31;
   localparam logic [CNT_W-1:0]    RECIP_STEPS_LAST  = 5'd15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DETUNE,
      ST_DEN,
      ST_RECIP,
      ST_PHASE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_left;
      logic signed [SAMPLE_W-1:0] sample_right;
      logic        [TARGET_W-1:0] detune_target;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
   } rsp_type;

endpackage

### rtl/core/dshr_div_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshr_div_unit
// Shared restoring-division step: one compare and subtract per cycle.
// ----------------------------------------------------------------------------
module dshr_div_unit (
   input  logic [dshr_pkg::DEN_W:0]   rem_in,
   input  logic [dshr_pkg::DEN_W-1:0] divisor,
   output logic [dshr_pkg::DEN_W-1:0] rem_out,
   output logic                       q_bit
);
   import dshr_pkg::*;

   logic [DEN_W:0] diff;

   always_comb begin
      diff  = rem_in - {1'b0, divisor};
      q_bit = (rem_in >= {1'b0, divisor});
      if (q_bit) begin
         rem_out = diff[DEN_W-1:0];
      end else begin
         rem_out = rem_in[DEN_W-1:0];
      end
   end

endmodule

### rtl/core/dshr_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshr_lane
// One channel: two cascaded sample-and-hold stages with phase accumulators.
// ----------------------------------------------------------------------------
module dshr_lane #(
   parameter int HOLD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic [HOLD_BITS-1:0]         sample,
   input  logic [dshr_pkg::RATIO_W-1:0] ratio_one,
   input  logic [dshr_pkg::RATIO_W-1:0] ratio_two,
   output logic [HOLD_BITS-1:0]         held
);
   import dshr_pkg::*;

   logic [PHASE_W-1:0]   phase_one_ff, phase_one_in;
   logic [PHASE_W-1:0]   phase_two_ff, phase_two_in;
   logic [HOLD_BITS-1:0] held_one_ff, held_one_in;
   logic [HOLD_BITS-1:0] held_two_ff, held_two_in;
   logic [PHASE_W:0]     sum_one, sum_two;

   always_comb begin
      sum_one      = {1'b0, phase_one_ff} + {1'b0, ratio_one};
      sum_two      = {1'b0, phase_two_ff} + {1'b0, ratio_two};
      phase_one_in = sum_one[PHASE_W-1:0];
      phase_two_in = sum_two[PHASE_W-1:0];
      held_one_in  = sum_one[PHASE_W] ? sample : held_one_ff;
      held_two_in  = sum_two[PHASE_W] ? held_one_in : held_two_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_one_ff <= '0;
         phase_two_ff <= '0;
         held_one_ff  <= '0;
         held_two_ff  <= '0;
      end else if (enable) begin
         phase_one_ff <= phase_one_in;
         phase_two_ff <= phase_two_in;
         held_one_ff  <= held_one_in;
         held_two_ff  <= held_two_in;
      end
   end

   assign held = held_two_ff;

endmodule

### rtl/core/double_sample_hold_rate_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_sample_hold_rate_reducer
// Detune ramp, reciprocal phase steps and two-stage sample-and-hold per
// channel, sequenced around one shared division step unit.
//
//   port group   dir   handshake          payload
//   req_         in    req_valid/stall    req_data (dshr_pkg::req_type)
//   rsp_         out   rsp_valid/stall    rsp_data (dshr_pkg::rsp_type)
//   csr_         in    csr_write          csr_data (ramp_frames)
//
// In bypass an item goes from the detune and denominator states to output;
// else two reciprocal divisions and the phase step follow, after a glide
// division if the detune target changes under a nonzero ramp_frames; the
// divider retires one quotient bit a cycle (32 for the glide, 16 per reciprocal).
// Synchronous reset clears the detune ramp, the hold lanes and ramp_frames
// to 960. req_stall is high while an item is in work; one finished item
// waits in the output register, so a stalled rsp_ side blocks only the next.
// ----------------------------------------------------------------------------
module double_sample_hold_rate_reducer #(
   parameter int CHANNELS    = dshr_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = dshr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dshr_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dshr_pkg::rsp_type             rsp_data,
   input  logic                          csr_write,
   input  logic [dshr_pkg::RAMP_W-1:0]   csr_data
);
   import dshr_pkg::*;

   localparam int HOLD_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [RAMP_W-1:0]     ramp_frames_ff;
   logic [DETUNE_W-1:0]   detune_now_ff, detune_now_in;
   logic [DETUNE_W-1:0]   ramp_step_ff, ramp_step_in;
   logic [RAMP_W-1:0]     ramp_left_ff, ramp_left_in;
   logic [TARGET_W-1:0]   last_target_ff, last_target_in;
   logic [TARGET_W-1:0]   tgt_ff, tgt_in;
   logic [HOLD_BITS-1:0]  left_ff, left_in;
   logic [HOLD_BITS-1:0]  right_ff, right_in;
   logic [RAMP_W-1:0]     n_ff, n_in;
   logic                  neg_ff, neg_in;
   logic [DETUNE_W-1:0]   mag_ff, mag_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pass_ff, pass_in;
   logic                  bypass_ff, bypass_in;
   logic [RATIO_W-1:0]    ratio_ff, ratio_in;
   logic [RATIO_W-1:0]    r1_ff, r1_in;

   logic [DEN_W:0]        unit_rem;
   logic [DEN_W-1:0]      unit_div;
   logic [DEN_W-1:0]      unit_out;
   logic                  unit_q;

   logic                  accept;
   logic                  lane_en;
   logic [TARGET_W-1:0]   tgt_sat;
   logic [RAMP_W-1:0]     n_cur;
   logic [DETUNE_W:0]     diff;
   logic [DETUNE_W-1:0]   tgt31;
   logic [DETUNE_W-1:0]   quot;
   logic [RAMP_W-1:0]     left_dec;
   logic [TARGET_W-1:0]   d_cur;
   logic [7:0]            k_sel;
   logic [DEN_W:0]        kd;
   logic [HOLD_BITS-1:0]  held_left, held_right;
   logic [SAMPLE_W-1:0]   out_right_run;

   dshr_div_unit u_div (
      .rem_in  (unit_rem),
      .divisor (unit_div),
      .rem_out (unit_out),
      .q_bit   (unit_q)
   );

   dshr_lane #(.HOLD_BITS(HOLD_BITS)) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .enable    (lane_en),
      .sample    (left_ff),
      .ratio_one (r1_ff),
      .ratio_two (ratio_ff),
      .held      (held_left)
   );

   generate
      if (CHANNELS >= 2) begin : g_right
         dshr_lane #(.HOLD_BITS(HOLD_BITS)) u_lane_right (
            .clock     (clock),
            .reset     (reset),
            .enable    (lane_en),
            .sample    (right_ff),
            .ratio_one (r1_ff),
            .ratio_two (ratio_ff),
            .held      (held_right)
         );
         assign out_right_run = SAMPLE_W'(held_right);
      end else begin : g_right_pass
         assign held_right    = right_ff;
         assign out_right_run = SAMPLE_W'(held_right);
      end
   endgenerate

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign lane_en   = (state_ff == ST_PHASE);

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      detune_now_in  = detune_now_ff;
      ramp_step_in   = ramp_step_ff;
      ramp_left_in   = ramp_left_ff;
      last_target_in = last_target_ff;
      tgt_in         = tgt_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      n_in           = n_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      cnt_in         = cnt_ff;
      pass_in        = pass_ff;
      bypass_in      = bypass_ff;
      ratio_in       = ratio_ff;
      r1_in          = r1_ff;

      tgt_sat  = (req_data.detune_target > Q16_ONE) ? Q16_ONE : req_data.detune_target;
      n_cur    = (ramp_frames_ff > RAMP_MAX) ? RAMP_MAX : ramp_frames_ff;
      diff     = {1'b0, tgt_sat, 15'b0} - {1'b0, detune_now_ff};
      tgt31    = {tgt_ff, 15'b0};
      quot     = {mag_ff[DETUNE_W-2:0], unit_q};
      left_dec = ramp_left_ff - RAMP_W'(1);
      d_cur    = detune_now_ff[DETUNE_W-1:15];
      k_sel    = pass_ff ? K_STAGE_TWO : K_STAGE_ONE;
      kd       = (DEN_W+1)'(d_cur) * (DEN_W+1)'(k_sel);

      if (state_ff == ST_DIV) begin
         unit_rem = {rem_ff, mag_ff[DETUNE_W-1]};
         unit_div = DEN_W'(n_ff);
      end else begin
         unit_rem = {rem_ff, 1'b0};
         unit_div = den_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tgt_in   = tgt_sat;
               left_in  = req_data.sample_left[HOLD_BITS-1:0];
               right_in = req_data.sample_right[HOLD_BITS-1:0];
               state_in = ST_DETUNE;
               if (req_data.detune_target != last_target_ff) begin
                  last_target_in = req_data.detune_target;
                  ramp_left_in   = n_cur;
                  if (n_cur != '0) begin
                     n_in     = n_cur;
                     neg_in   = diff[DETUNE_W];
                     mag_in   = diff[DETUNE_W] ? DETUNE_W'(-diff) : diff[DETUNE_W-1:0];
                     rem_in   = '0;
                     cnt_in   = DIV_STEPS_LAST;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in = unit_out;
            mag_in = quot;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               ramp_step_in = neg_ff ? -quot : quot;
               state_in     = ST_DETUNE;
            end
         end
         ST_DETUNE: begin
            if (ramp_left_ff == '0) begin
               detune_now_in = tgt31;
            end else begin
               ramp_left_in = left_dec;
               if (left_dec != '0) begin
                  detune_now_in = detune_now_ff + ramp_step_ff;
               end else begin
                  detune_now_in = tgt31;
               end
            end
            pass_in  = 1'b0;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            bypass_in = (d_cur < BYPASS_LIMIT);
            den_in    = RECIP_BASE + kd[DEN_W-1:0];
            rem_in    = RECIP_BASE;
            cnt_in    = RECIP_STEPS_LAST;
            state_in  = (d_cur < BYPASS_LIMIT) ? ST_DONE : ST_RECIP;
         end
         ST_RECIP: begin
            rem_in   = unit_out;
            ratio_in = {ratio_ff[RATIO_W-2:0], unit_q};
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (!pass_ff) begin
                  r1_in    = ratio_in;
                  pass_in  = 1'b1;
                  state_in = ST_DEN;
               end else begin
                  state_in = ST_PHASE;
               end
            end
         end
         ST_PHASE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (bypass_ff) begin
                  rsp_data_in.out_left  = SAMPLE_W'(left_ff);
                  rsp_data_in.out_right = SAMPLE_W'(right_ff);
               end else begin
                  rsp_data_in.out_left  = SAMPLE_W'(held_left);
                  rsp_data_in.out_right = out_right_run;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         ramp_frames_ff <= RAMP_FRAMES_RESET;
         detune_now_ff  <= '0;
         ramp_step_ff   <= '0;
         ramp_left_ff   <= '0;
         last_target_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write) begin
            ramp_frames_ff <= csr_data;
         end
         detune_now_ff  <= detune_now_in;
         ramp_step_ff   <= ramp_step_in;
         ramp_left_ff   <= ramp_left_in;
         last_target_ff <= last_target_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      tgt_ff      <= tgt_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      pass_ff     <= pass_in;
      bypass_ff   <= bypass_in;
      ratio_ff    <= ratio_in;
      r1_ff       <= r1_in;
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_sample_hold_rate_reducer. Every accepted
// frame goes through a local copy of the detune glide and the two hold stages.
// The copy predicts the output frame, and each returned frame is compared
// field by field. Directed frames cover bypass, the glide corner cases and
// the sample extremes. Random glide sequences follow, each under its own ramp
// length, with random idling on both sides. An output hold-off and a sender
// pause come next, and an idle-free tail ends the run.
// ----------------------------------------------------------------------------
module tb;
   import dshr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [RAMP_W-1:0] csr_data = '0;

   double_sample_hold_rate_reducer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_data(csr_data)
   );

   // local copy of the block state
   logic [RAMP_W-1:0] ramp_len = RAMP_FRAMES_RESET;
   logic [31:0] cur_detune = '0;
   logic [31:0] glide_step = '0;
   int unsigned glide_left = 0;
   logic [TARGET_W-1:0] prev_target = '0;
   logic [17:0] ph_one [2] = '{default: '0};
   logic [17:0] ph_two [2] = '{default: '0};
   logic [SAMPLE_W-1:0] smp_one [2] = '{default: '0};
   logic [SAMPLE_W-1:0] smp_two [2] = '{default: '0};

   rsp_type out_frame_q [$];
   rsp_type want;
   int fail_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;
   int hold_req = 0;
   int hold_cnt = 0;
   int burst_cnt = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic rsp_type reduce_frame(input req_type f);
      logic [TARGET_W-1:0] tgt;
      logic [31:0] tgt31;
      longint diff;
      longint st;
      int unsigned span;
      logic [31:0] d;
      logic [63:0] r1;
      logic [63:0] r2;
      logic [SAMPLE_W-1:0] x [2];
      rsp_type o;
      tgt = (f.detune_target > Q16_ONE) ? Q16_ONE : f.detune_target;
      tgt31 = {tgt[16:0], 15'd0};
      if (f.detune_target != prev_target) begin
         span = 32'((ramp_len > RAMP_MAX) ? RAMP_MAX : ramp_len);
         prev_target = f.detune_target;
         if (span == 0) begin
            cur_detune = tgt31;
            glide_left = 0;
         end else begin
            diff = longint'(tgt31) - longint'(cur_detune);
            st = diff / longint'(span);
            glide_step = st[31:0];
            glide_left = span;
         end
      end
      if (glide_left == 0) begin
         cur_detune = tgt31;
      end else begin
         glide_left--;
         if (glide_left > 0) cur_detune = cur_detune + glide_step;
         else cur_detune = tgt31;
      end
      d = cur_detune >> 15;
      o.out_left = f.sample_left;
      o.out_right = f.sample_right;
      if (d < BYPASS_LIMIT) return o;
      r1 = 64'd429496729600 / (64'(RECIP_BASE) + 64'(K_STAGE_ONE) * 64'(d));
      r2 = 64'd429496729600 / (64'(RECIP_BASE) + 64'(K_STAGE_TWO) * 64'(d));
      x[0] = f.sample_left;
      x[1] = f.sample_right;
      for (int c = 0; c < 2; c++) begin
         ph_one[c] = ph_one[c] + r1[17:0];
         if (ph_one[c] >= 18'(Q16_ONE)) begin
            ph_one[c] = ph_one[c] - 18'(Q16_ONE);
            smp_one[c] = x[c];
         end
         ph_two[c] = ph_two[c] + r2[17:0];
         if (ph_two[c] >= 18'(Q16_ONE)) begin
            ph_two[c] = ph_two[c] - 18'(Q16_ONE);
            smp_two[c] = smp_one[c];
         end
      end
      o.out_left = smp_two[0];
      o.out_right = smp_two[1];
      return o;
   endfunction

   function automatic req_type rand_frame(input logic [TARGET_W-1:0] tgt);
      req_type f;
      f.sample_left = SAMPLE_W'($urandom());
      f.sample_right = SAMPLE_W'($urandom());
      f.detune_target = tgt;
      return f;
   endfunction

   function automatic req_type make_frame(input int sl, input int sr, input int tgt);
      req_type f;
      f.sample_left = sl[SAMPLE_W-1:0];
      f.sample_right = sr[SAMPLE_W-1:0];
      f.detune_target = tgt[TARGET_W-1:0];
      return f;
   endfunction

   function automatic logic [TARGET_W-1:0] pick_target();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return Q16_ONE;
         2: return TARGET_W'($urandom_range(0, 131071));
         3: return TARGET_W'($urandom_range(60, 72));
         default: return TARGET_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [RAMP_W-1:0] pick_ramp();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return 14'd1;
         2: return RAMP_MAX;
         3: return 14'd16383;
         4: return RAMP_FRAMES_RESET;
         5: return RAMP_W'($urandom_range(8193, 16383));
         6: return RAMP_W'($urandom_range(100, 8191));
         default: return RAMP_W'($urandom_range(1, 16));
      endcase
   endfunction

   // valid stays high after acceptance; the next call raises or drops it
   task automatic send_frame(input req_type f);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (req_stall);
      out_frame_q.push_back(reduce_frame(f));
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      while (out_frame_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_ramp(input logic [RAMP_W-1:0] v);
      drain_frames();
      @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      ramp_len = v;
   endtask

   task automatic test_bypass();
      send_frame(make_frame(8388607, 8388607, 0));
      send_frame(make_frame(-8388608, -8388608, 0));
      send_frame(make_frame(0, -1, 0));
   endtask

   task automatic test_ramp_jump();
      set_ramp('0);
      send_frame(make_frame(8388607, -8388608, 65));
      send_frame(make_frame(-8388608, 8388607, 66));
      send_frame(make_frame(8388607, 0, 65536));
      send_frame(make_frame(-1, -8388608, 131071));
      send_frame(make_frame(0, 8388607, 65536));
      send_frame(make_frame(-8388608, -1, 65536));
   endtask

   task automatic test_glides();
      set_ramp(14'd3);
      repeat (4) send_frame(rand_frame(17'd40000));
      // above the maximum length, glides down with a negative step
      set_ramp(14'd16383);
      repeat (2) send_frame(rand_frame('0));
      // new length must not touch the glide in progress
      set_ramp(14'd1);
      repeat (2) send_frame(rand_frame('0));
      send_frame(rand_frame(17'd1000));
   endtask

   task automatic test_random_glides(input int frames);
      int sent;
      int run;
      logic [TARGET_W-1:0] tgt;
      sent = 0;
      while (sent < frames) begin
         set_ramp(pick_ramp());
         repeat ($urandom_range(4, 8)) begin
            tgt = pick_target();
            run = int'($urandom_range(1, 30));
            repeat (run) begin
               if ($urandom_range(0, 9) == 0)
                  send_frame(rand_frame(TARGET_W'($urandom_range(0, 131071))));
               else
                  send_frame(rand_frame(tgt));
               sent++;
            end
         end
      end
   endtask

   task automatic test_output_holdoff();
      set_ramp(14'd4);
      hold_req = 400;
      repeat (8) send_frame(rand_frame(17'd50000));
      drain_frames();
   endtask

   task automatic test_sender_pause();
      repeat (10) send_frame(rand_frame(pick_target()));
      drain_frames();
      repeat (10) send_frame(rand_frame(pick_target()));
   endtask

   task automatic test_quiet_tail();
      logic [TARGET_W-1:0] tgt;
      set_ramp(14'd2);
      idle_on = 1'b0;
      repeat (6) begin
         tgt = pick_target();
         repeat ($urandom_range(8, 20)) send_frame(rand_frame(tgt));
      end
   endtask

   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_cnt = hold_req;
         hold_req = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt--;
      end else if (burst_cnt > 0) begin
         rsp_stall <= 1'b1;
         burst_cnt--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         burst_cnt = int'($urandom_range(0, 2));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (out_frame_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected frame: left %0d right %0d",
                        rsp_data.out_left, rsp_data.out_right);
         end else begin
            want = out_frame_q.pop_front();
            if (rsp_data.out_left !== want.out_left ||
                rsp_data.out_right !== want.out_right) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("frame mismatch: left exp %0d got %0d, right exp %0d got %0d",
                           want.out_left, rsp_data.out_left,
                           want.out_right, rsp_data.out_right);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_bypass();
      test_ramp_jump();
      test_glides();
      test_random_glides(1600);
      test_output_holdoff();
      test_sender_pause();
      test_quiet_tail();
      drain_frames();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (out_frame_q.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
